### rtl/nts_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants for the nearest timepoint search unit
package nts_pkg;

  localparam int unsigned TABLE_DEPTH_DEFAULT = 4096;
  localparam int unsigned TP_W  = 64;
  localparam int unsigned IDX_W = 12;

  // operation codes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // where the reported index comes from
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_LAST,
    SRC_PICK
  } nts_src_e;

  typedef struct packed {
    logic [1:0]      operation;
    logic [TP_W-1:0] timepoint;
  } nts_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] nearest_index;
  } nts_out_t;

  typedef struct packed {
    logic       accept;
    logic       do_append;
    logic       do_clear;
    logic       search_step;
    logic       rd_lo;
    logic       cap_hi;
    logic       cap_lo;
    logic       finish;
    nts_src_e   src;
    logic [1:0] status;
  } nts_cmd_t;

  typedef struct packed {
    logic table_empty;
    logic table_full;
    logic search_done;
    logic hi_zero;
    logic hi_end;
  } nts_stat_t;

endpackage

### rtl/nearest_timepoint_search_unit.sv
`timescale 1ns / 1ps
// top level: sorted timepoint table with nearest-entry lookup
// append, clear and the unused code: result strobe in the cycle after acceptance, busy stays
//   low, so one transaction per cycle
// query on n entries: one memory probe per lower-bound step, then at most two neighbor
//   reads and the pick before the result strobe
// reset clears the entry count and control state; table contents stay, no clearing pass
// results are shown for one cycle only, the receiver cannot stall
module nearest_timepoint_search_unit #(
  parameter int unsigned TABLE_DEPTH = nts_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  nts_pkg::nts_in_t  in_i,
  output logic              busy_o,
  output logic              done_o,
  output nts_pkg::nts_out_t res_o
);
  import nts_pkg::*;

  // command and status between the sequencer and the datapath
  nts_cmd_t  cmd;
  nts_stat_t stat;

  // controller: accepts a transaction when start is seen while idle, then steps the search
  nts_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (in_i.operation),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // datapath: the table lives in a single-port-read memory with registered read data;
  // each lower-bound step compares the registered probe and issues the next address
  nts_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // any transaction other than a query answers in the very next cycle
  a_quick_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (in_i.operation != OP_QUERY)) |=> done_o)
    else $error("non-query transaction did not answer in the next cycle");

  // a query finishing its search always delivers a result as busy drops
  a_done_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result strobe");

  // error results never carry an index
  a_err_zero_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status != ST_OK)) |-> (res_o.nearest_index == '0))
    else $error("error status with a nonzero index");

  // a strobe only follows an accepted transaction or a running query
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i || busy_o))
    else $error("result strobe without a transaction");

endmodule

### rtl/nts_dpath.sv
`timescale 1ns / 1ps
// datapath: timepoint memory, entry count, lower-bound search registers and result register
module nts_dpath #(
  parameter int unsigned TABLE_DEPTH = nts_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nts_pkg::nts_in_t   in_i,
  input  nts_pkg::nts_cmd_t  cmd_i,
  output nts_pkg::nts_stat_t stat_o,
  output logic               done_o,
  output nts_pkg::nts_out_t  res_o
);
  import nts_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FullCount = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] One = CW'(1);

  function automatic logic [TP_W-1:0] abs_diff(input logic [TP_W-1:0] a,
                                               input logic [TP_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic [TP_W-1:0] mem [TABLE_DEPTH];

  logic [CW-1:0]   count_q;
  logic [CW-1:0]   first_q, first_d;
  logic [CW-1:0]   span_q, span_d;
  logic [CW-1:0]   half;
  logic [CW-1:0]   probe;
  logic [AW-1:0]   rd_addr;
  logic [TP_W-1:0] t_q;
  logic [TP_W-1:0] rd_data_q;
  logic [TP_W-1:0] d_hi_q;
  logic [TP_W-1:0] d_lo_q;
  logic            lt;
  logic [CW-1:0]   idx_sel;
  logic [31:0]     idx_wide;
  logic            done_q;
  nts_out_t        res_q;

  assign half = span_q >> 1;
  assign lt   = rd_data_q < t_q;

  // one lower-bound step per cycle
  always_comb begin
    first_d = first_q;
    span_d  = span_q;
    if (cmd_i.accept) begin
      first_d = '0;
      span_d  = count_q;
    end else if (cmd_i.search_step) begin
      if (lt) begin
        first_d = first_q + half + One;
        span_d  = span_q - half - One;
      end else begin
        span_d  = half;
      end
    end
  end

  // next probe, or the entry below the lower bound
  assign probe   = first_d + (span_d >> 1);
  assign rd_addr = cmd_i.rd_lo ? AW'(first_q - One) : AW'(probe);

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_append) begin
      mem[count_q[AW-1:0]] <= in_i.timepoint;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    span_q  <= span_d;
    if (cmd_i.accept) begin
      t_q <= in_i.timepoint;
    end
    if (cmd_i.cap_hi) begin
      d_hi_q <= abs_diff(rd_data_q, t_q);
    end
    if (cmd_i.cap_lo) begin
      d_lo_q <= abs_diff(t_q, rd_data_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.do_clear) begin
      count_q <= '0;
    end else if (cmd_i.do_append) begin
      count_q <= count_q + One;
    end
  end

  always_comb begin
    unique case (cmd_i.src)
      SRC_LAST: idx_sel = count_q - One;
      SRC_PICK: idx_sel = (d_hi_q < d_lo_q) ? first_q : (first_q - One);
      default:  idx_sel = '0;
    endcase
  end

  assign idx_wide = 32'(idx_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q.status        <= cmd_i.status;
      res_q.nearest_index <= idx_wide[IDX_W-1:0];
    end
  end

  assign stat_o.table_empty = (count_q == '0);
  assign stat_o.table_full  = (count_q == FullCount);
  assign stat_o.search_done = (span_d == '0);
  assign stat_o.hi_zero     = (first_q == '0);
  assign stat_o.hi_end      = (first_q >= count_q);

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### rtl/nts_ctrl.sv
`timescale 1ns / 1ps
// controller state machine sequencing append, clear and the nearest search
module nts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         op_i,
  input  nts_pkg::nts_stat_t stat_i,
  output nts_pkg::nts_cmd_t  cmd_o,
  output logic               busy_o
);
  import nts_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_LO     = 3'd3;
  localparam logic [2:0] S_PICK   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.src    = SRC_ZERO;
    cmd_o.status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          unique case (op_i)
            OP_APPEND: begin
              cmd_o.finish = 1'b1;
              if (stat_i.table_full) begin
                cmd_o.status = ST_FULL;
              end else begin
                cmd_o.do_append = 1'b1;
              end
            end
            OP_CLEAR: begin
              cmd_o.do_clear = 1'b1;
              cmd_o.finish   = 1'b1;
            end
            OP_QUERY: begin
              if (stat_i.table_empty) begin
                cmd_o.finish = 1'b1;
                cmd_o.status = ST_EMPTY;
              end else begin
                state_d = S_SEARCH;
              end
            end
            default: begin
              cmd_o.finish = 1'b1;
            end
          endcase
        end
      end
      S_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (stat_i.search_done) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat_i.hi_zero) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else if (stat_i.hi_end) begin
          cmd_o.finish = 1'b1;
          cmd_o.src    = SRC_LAST;
          state_d      = S_IDLE;
        end else begin
          cmd_o.rd_lo  = 1'b1;
          cmd_o.cap_hi = 1'b1;
          state_d      = S_LO;
        end
      end
      S_LO: begin
        cmd_o.cap_lo = 1'b1;
        state_d      = S_PICK;
      end
      S_PICK: begin
        cmd_o.finish = 1'b1;
        cmd_o.src    = SRC_PICK;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### bench/nearest_timepoint_search_unit_tb.sv
`timescale 1ns / 1ps
// testbench for the nearest timepoint search unit: directed and random append/clear/query traffic
// checked against a behavioral lookup of the same table
module nearest_timepoint_search_unit_tb;
  import nts_pkg::*;

  localparam int unsigned DEPTH        = TABLE_DEPTH_DEFAULT;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;     // operation code the block ignores
  localparam logic [63:0] ALL_ONES     = '1;
  localparam int unsigned RANDOM_ITEMS = 880;
  localparam int unsigned FILL_ITEMS   = 512;      // long sorted load for deep searches
  // far above the longest query plus the longest idle gap the sender inserts
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 24;       // settle time after the last result

  typedef struct {
    nts_in_t     txn;
    int unsigned gap;     // idle cycles before this transaction is offered
    bit          drain;   // hold off until every outstanding result has come back
  } txn_slot_t;

  typedef struct {
    nts_in_t  txn;
    nts_out_t resp;
  } resp_due_t;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start_i;
  nts_in_t  in_i;
  logic     busy_o;
  logic     done_o;
  nts_out_t res_o;

  nearest_timepoint_search_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .in_i   (in_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // behavioral copy of the timepoint table
  // ---------------------------------------------------------------------------
  bit [63:0]   tp_table [DEPTH];
  int unsigned tp_count;

  // tallies for the closing summary
  int unsigned n_stored, n_dropped, n_clear, n_query, n_empty, n_ignored, peak_count;

  // first index whose entry is not below t, or tp_count when there is none
  function automatic int unsigned first_at_or_above(bit [63:0] t);
    int unsigned lo_idx;
    int unsigned span;
    int unsigned half;
    lo_idx = 0;
    span   = tp_count;
    while (span > 0) begin
      half = span / 2;
      if (tp_table[lo_idx + half] < t) begin
        lo_idx += half + 1;
        span   -= half + 1;
      end else begin
        span = half;
      end
    end
    return lo_idx;
  endfunction

  function automatic int unsigned nearest_entry(bit [63:0] t);
    int unsigned hi;
    bit [63:0]   d_hi;
    bit [63:0]   d_lo;
    hi = first_at_or_above(t);
    if (hi == 0) return 0;
    if (hi >= tp_count) return tp_count - 1;
    d_hi = (tp_table[hi] > t) ? tp_table[hi] - t : t - tp_table[hi];
    d_lo = (tp_table[hi-1] > t) ? tp_table[hi-1] - t : t - tp_table[hi-1];
    // equal distance goes to the lower neighbor
    return (d_hi < d_lo) ? hi : hi - 1;
  endfunction

  // applies one transaction to the table copy and returns the response it must produce
  function automatic nts_out_t lookup_response(nts_in_t txn);
    nts_out_t    r;
    int unsigned pick;
    r.status        = ST_OK;
    r.nearest_index = '0;
    case (txn.operation)
      OP_APPEND: begin
        if (tp_count < DEPTH) begin
          tp_table[tp_count] = txn.timepoint;
          tp_count++;
          n_stored++;
          if (tp_count > peak_count) peak_count = tp_count;
        end else begin
          r.status = ST_FULL;
          n_dropped++;
        end
      end
      OP_CLEAR: begin
        tp_count = 0;
        n_clear++;
      end
      OP_QUERY: begin
        n_query++;
        if (tp_count == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          pick            = nearest_entry(txn.timepoint);
          r.nearest_index = pick[IDX_W-1:0];
        end
      end
      default: n_ignored++;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus store and generators
  // ---------------------------------------------------------------------------
  txn_slot_t   txn_q[$];
  resp_due_t   resp_due_q[$]; // transactions taken and still waiting for their result
  bit [63:0]   seq_vals[$];   // timepoints appended by the current sequence
  bit          no_idle;
  int unsigned stim_cnt;

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_txn(input logic [1:0] op, input logic [63:0] tp, input bit drain);
    txn_slot_t s;
    s.txn.operation = op;
    s.txn.timepoint = tp;
    s.gap           = no_idle ? 0 : $urandom_range(0, 8);
    s.drain         = drain;
    txn_q.push_back(s);
    if (op != OP_UNUSED) stim_cnt++;
  endtask

  // non-decreasing run of appends; step width drawn once per run, saturating at the top
  task automatic queue_sorted_appends(input int unsigned n, input bit [63:0] first_tp,
                                      input int unsigned max_shift);
    bit [63:0]   v;
    bit [63:0]   nxt;
    int unsigned shift;
    v     = first_tp;
    shift = $urandom_range(0, max_shift);
    for (int unsigned i = 0; i < n; i++) begin
      queue_txn(OP_APPEND, v, 1'b0);
      seq_vals.push_back(v);
      nxt = v + (rand64() >> (63 - shift));
      v   = (nxt < v) ? ALL_ONES : nxt;
    end
  endtask

  // queries at stored values, their neighbors and midpoints, the extremes, or random values
  task automatic queue_queries(input int unsigned m);
    bit [63:0]   a;
    bit [63:0]   b;
    bit [63:0]   q;
    int unsigned j;
    for (int unsigned i = 0; i < m; i++) begin
      q = rand64();
      if (seq_vals.size() != 0) begin
        j = $urandom_range(0, seq_vals.size() - 1);
        a = seq_vals[j];
        b = (j + 1 < seq_vals.size()) ? seq_vals[j+1] : ALL_ONES;
        case ($urandom_range(0, 7))
          0: q = a;
          1: q = a + 1;
          2: q = a - 1;
          3: q = a + (b - a) / 2;        // exact tie whenever the gap is even
          4: q = a + (b - a + 1) / 2;
          5: q = $urandom_range(0, 1) ? ALL_ONES : 64'd0;
          default: ;
        endcase
      end
      queue_txn(OP_QUERY, q, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued transactions, changes inputs on the falling edge
  // ---------------------------------------------------------------------------
  logic      took_q;     // the transaction on the inputs was taken at the last rising edge
  txn_slot_t cur;
  bit        have_cur;

  always @(negedge clk_i) begin : drive_p
    logic    nxt_start;
    nts_in_t nxt_in;
    if (rst_ni) begin
      nxt_start = start_i;
      nxt_in    = in_i;
      if (start_i && took_q) nxt_start = 1'b0;
      if (!nxt_start) begin
        if (!have_cur && txn_q.size() != 0) begin
          cur      = txn_q.pop_front();
          have_cur = 1'b1;
        end
        if (have_cur) begin
          if (cur.gap != 0) begin
            cur.gap--;
          end else if (!cur.drain || resp_due_q.size() == 0) begin
            nxt_start = 1'b1;
            nxt_in    = cur.txn;
            have_cur  = 1'b0;
          end
        end
      end
      // one update per signal, so a back-to-back start simply stays high
      start_i <= nxt_start;
      in_i    <= nxt_in;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result strobe, then predicts the transaction taken this edge
  // ---------------------------------------------------------------------------
  resp_due_t   due;
  int unsigned fail_cnt;
  int unsigned accept_cnt;
  int unsigned result_cnt;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      took_q <= 1'b0;
    end else begin
      took_q <= start_i && !busy_o;
      // a result never belongs to the transaction taken at the same edge
      if (done_o) begin
        result_cnt++;
        if (resp_due_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected result: status %0d index %0d",
                     res_o.status, res_o.nearest_index);
        end else begin
          due = resp_due_q.pop_front();
          if (res_o.status !== due.resp.status ||
              res_o.nearest_index !== due.resp.nearest_index) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: op %0d tp %h: expected status %0d index %0d, got %0d %0d",
                       due.txn.operation, due.txn.timepoint, due.resp.status,
                       due.resp.nearest_index, res_o.status, res_o.nearest_index);
          end
        end
      end
      if (start_i && !busy_o) begin
        accept_cnt++;
        due.txn  = in_i;
        due.resp = lookup_response(in_i);
        resp_due_q.push_back(due);
      end
    end
  end

  // watchdog: too long without any transaction or result ends the run
  int unsigned stall_cnt;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("timeout: no activity for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus plan, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    bit [63:0]   base;
    int unsigned n;
    int unsigned rand_start;

    start_i   = 1'b0;
    in_i      = '0;
    rst_ni    = 1'b0;
    have_cur  = 1'b0;
    no_idle   = 1'b0;
    stim_cnt  = 0;
    tp_count  = 0;
    fail_cnt  = 0;
    stall_cnt = 0;

    // directed: empty table, ignored code, field extremes, ties, out-of-order append
    queue_txn(OP_QUERY,  64'd5,     1'b0);   // query on empty table
    queue_txn(OP_UNUSED, ALL_ONES,  1'b0);
    queue_txn(OP_APPEND, 64'd0,     1'b0);
    queue_txn(OP_QUERY,  64'd0,     1'b0);
    queue_txn(OP_QUERY,  ALL_ONES,  1'b1);   // past the end of a single entry
    queue_txn(OP_APPEND, 64'd10,    1'b0);
    queue_txn(OP_APPEND, 64'd20,    1'b0);
    queue_txn(OP_APPEND, ALL_ONES,  1'b0);
    queue_txn(OP_QUERY,  64'd15,    1'b0);   // tie between 10 and 20
    queue_txn(OP_QUERY,  64'd16,    1'b0);
    queue_txn(OP_QUERY,  64'd14,    1'b0);
    queue_txn(OP_QUERY,  64'd0,     1'b0);
    queue_txn(OP_QUERY,  ALL_ONES,  1'b0);
    queue_txn(OP_QUERY,  ALL_ONES - 1, 1'b0);
    queue_txn(OP_APPEND, 64'd5,     1'b0);   // breaks the ordering
    queue_txn(OP_QUERY,  64'd7,     1'b0);
    queue_txn(OP_QUERY,  64'h8000_0000_0000_0000, 1'b0);
    queue_txn(OP_CLEAR,  ALL_ONES,  1'b1);
    queue_txn(OP_QUERY,  64'd0,     1'b0);   // empty again after clear
    queue_txn(OP_UNUSED, 64'd0,     1'b0);
    queue_txn(OP_APPEND, ALL_ONES,  1'b0);
    queue_txn(OP_QUERY,  64'd0,     1'b0);
    queue_txn(OP_CLEAR,  64'd0,     1'b0);

    // one long sorted load, then searches across all of it
    seq_vals.delete();
    queue_sorted_appends(FILL_ITEMS, 64'd0, 40);
    queue_queries(24);
    queue_txn(OP_QUERY, 64'd0,    1'b0);
    queue_txn(OP_QUERY, ALL_ONES, 1'b1);
    queue_txn(OP_CLEAR, rand64(), 1'b0);

    // random part: mostly clear / sorted load / queries, with noise mixed in
    rand_start = stim_cnt;
    while (stim_cnt - rand_start < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          seq_vals.delete();
          if ($urandom_range(0, 4) != 0)
            queue_txn(OP_CLEAR, rand64(), $urandom_range(0, 7) == 0);
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
          case ($urandom_range(0, 3))
            0:       base = '0;
            1:       base = rand64();
            2:       base = ALL_ONES - $urandom_range(0, 40);
            default: base = rand64() >> $urandom_range(1, 63);
          endcase
          queue_sorted_appends(n, base, $urandom_range(0, 63));
          queue_queries($urandom_range(1, 12));
        end
        7: begin
          seq_vals.delete();
          queue_txn(OP_CLEAR, rand64(), 1'b0);
          queue_queries($urandom_range(1, 3));
        end
        default: begin
          // noise: any code, unordered timepoints
          n = $urandom_range(1, 10);
          for (int unsigned i = 0; i < n; i++)
            queue_txn(2'($urandom_range(0, 3)),
                      $urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 64)),
                      1'b0);
        end
      endcase
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (txn_q.size() != 0 || have_cur || start_i) @(posedge clk_i);
    while (resp_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (resp_due_q.size() != 0) fail_cnt++;

    $display("run: %0d transactions, %0d results; %0d appends stored, %0d dropped on full table",
             accept_cnt, result_cnt, n_stored, n_dropped);
    $display("run: %0d queries (%0d on empty table), %0d clears, %0d ignored, peak %0d entries",
             n_query, n_empty, n_clear, n_ignored, peak_count);
    if (fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
